>>> rtl/core/xxh32_pkg.sv
`default_nettype none

package xxh32_pkg;

    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_count;

    localparam t_word PRIME1 = 32'd2654435761;
    localparam t_word PRIME2 = 32'd2246822519;
    localparam t_word PRIME3 = 32'd3266489917;
    localparam t_word PRIME4 = 32'd668265263;
    localparam t_word PRIME5 = 32'd374761393;

    localparam int unsigned LANES = 4;

    // bit 2 of the byte address selects the register word
    localparam logic REG_SEED = 1'b0;

    function automatic t_word rotl(input t_word x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/xxh32_in_if.sv
`default_nettype none

interface xxh32_in_if
    import xxh32_pkg::*;
();
    logic   valid;
    logic   ready;
    t_word  data_word;
    t_count byte_count;
    logic   last_word;

    modport source (output valid, output data_word, output byte_count, output last_word,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last_word,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/xxh32_out_if.sv
`default_nettype none

interface xxh32_out_if
    import xxh32_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/xxhash32_message_hash.sv
`default_nettype none

// Channel    Dir  Payload                                 Handshake
// i_word_ch  in   data_word[31:0] byte_count[2:0] last    valid/ready
// o_hash_ch  out  hash_value[31:0]                        valid/ready
// apb (psel) in   seed at byte address 0                  psel/penable/pwrite, pready=1
//
// One 32x32 multiplier (low half, registered) is shared by every round.
// A word that does not finish a stripe returns to idle; one that does absorbs
// the four lanes (multiply, multiply, write per lane). The last word adds the
// fold (lanes only once a stripe was seen), a multiply, rotate and write per
// tail word and tail byte, then avalanche and emit. Ready is high only while
// the sequencer is idle. Synchronous active-low reset; the result register
// holds a hash until taken, and the next message may start while it waits.
module xxhash32_message_hash
    import xxh32_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    xxh32_in_if.sink     i_word_ch,
    xxh32_out_if.source  o_hash_ch,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_AB_MUL1 = 4'd1;
    localparam logic [3:0] S_AB_MUL2 = 4'd2;
    localparam logic [3:0] S_AB_WR   = 4'd3;
    localparam logic [3:0] S_FOLD0   = 4'd4;
    localparam logic [3:0] S_FOLD    = 4'd5;
    localparam logic [3:0] S_TW_MUL  = 4'd6;
    localparam logic [3:0] S_TW_ROT  = 4'd7;
    localparam logic [3:0] S_TW_WR   = 4'd8;
    localparam logic [3:0] S_TB_MUL  = 4'd9;
    localparam logic [3:0] S_TB_ROT  = 4'd10;
    localparam logic [3:0] S_TB_WR   = 4'd11;
    localparam logic [3:0] S_AV1     = 4'd12;
    localparam logic [3:0] S_AV2     = 4'd13;
    localparam logic [3:0] S_EMIT    = 4'd14;

    logic [3:0]  r_state, n_state;
    t_word       r_seed;
    t_word       r_lane [LANES];
    t_word       r_buf  [LANES];
    logic [1:0]  r_nbuf;
    t_word       r_total;
    logic        r_seen;
    logic        r_last;
    t_word       r_word;
    logic [1:0]  r_cnt;
    logic [1:0]  r_idx;
    t_word       r_h;
    t_word       r_prod;
    logic        r_out_valid;
    t_word       r_hash;

    logic        w_in_acc;
    logic        w_push;
    t_count      w_cnt_sat;
    logic        w_out_free;
    logic        w_cfg_wr;
    t_word       w_mul_a, w_mul_b, w_prod;
    t_word       w_fold_rot;
    t_word       w_byte;
    logic [3:0]  w_tail_state;
    logic [3:0]  w_byte_state;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_SEED) ? r_seed : 32'd0;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);

    assign i_word_ch.ready  = (r_state == S_IDLE);
    assign w_in_acc         = i_word_ch.valid && i_word_ch.ready;
    assign w_cnt_sat        = (i_word_ch.byte_count > 3'd4) ? 3'd4 : i_word_ch.byte_count;
    assign w_push           = !i_word_ch.last_word || (w_cnt_sat == 3'd4);

    assign o_hash_ch.valid      = r_out_valid;
    assign o_hash_ch.hash_value = r_hash;
    assign w_out_free           = !r_out_valid || o_hash_ch.ready;

    assign w_byte = {24'd0, r_word[{r_idx, 3'b000} +: 8]};

    always_comb begin
        unique case (r_idx)
            2'd0:    w_fold_rot = rotl(r_lane[0], 1);
            2'd1:    w_fold_rot = rotl(r_lane[1], 7);
            2'd2:    w_fold_rot = rotl(r_lane[2], 12);
            default: w_fold_rot = rotl(r_lane[3], 18);
        endcase
    end

    assign w_byte_state = (r_cnt != 2'd0) ? S_TB_MUL : S_AV1;
    assign w_tail_state = (r_nbuf != 2'd0) ? S_TW_MUL : w_byte_state;

    // shared multiplier operand selection
    always_comb begin
        w_mul_a = r_prod;
        w_mul_b = PRIME1;
        unique case (r_state)
            S_AB_MUL1: begin
                w_mul_a = r_buf[r_idx];
                w_mul_b = PRIME2;
            end
            S_AB_MUL2: begin
                w_mul_a = rotl(r_lane[r_idx] + r_prod, 13);
                w_mul_b = PRIME1;
            end
            S_TW_MUL: begin
                w_mul_a = r_buf[r_idx];
                w_mul_b = PRIME3;
            end
            S_TW_ROT: begin
                w_mul_a = rotl(r_h + r_prod, 17);
                w_mul_b = PRIME4;
            end
            S_TB_MUL: begin
                w_mul_a = w_byte;
                w_mul_b = PRIME5;
            end
            S_TB_ROT: begin
                w_mul_a = rotl(r_h + r_prod, 11);
                w_mul_b = PRIME1;
            end
            S_AV1: begin
                w_mul_a = r_h ^ (r_h >> 15);
                w_mul_b = PRIME2;
            end
            S_AV2: begin
                w_mul_a = r_prod ^ (r_prod >> 13);
                w_mul_b = PRIME3;
            end
            default: begin
                w_mul_a = r_prod;
                w_mul_b = PRIME1;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_push && r_nbuf == 2'd3)        n_state = S_AB_MUL1;
                    else if (i_word_ch.last_word)        n_state = S_FOLD0;
                    else                                 n_state = S_IDLE;
                end
            end
            S_AB_MUL1: n_state = S_AB_MUL2;
            S_AB_MUL2: n_state = S_AB_WR;
            S_AB_WR: begin
                if (r_idx == 2'd3) n_state = r_last ? S_FOLD0 : S_IDLE;
                else               n_state = S_AB_MUL1;
            end
            S_FOLD0:   n_state = r_seen ? S_FOLD : w_tail_state;
            S_FOLD:    n_state = (r_idx == 2'd3) ? w_tail_state : S_FOLD;
            S_TW_MUL:  n_state = S_TW_ROT;
            S_TW_ROT:  n_state = S_TW_WR;
            S_TW_WR:   n_state = (r_idx == r_nbuf - 2'd1) ? w_byte_state : S_TW_MUL;
            S_TB_MUL:  n_state = S_TB_ROT;
            S_TB_ROT:  n_state = S_TB_WR;
            S_TB_WR:   n_state = (r_idx == r_cnt - 2'd1) ? S_AV1 : S_TB_MUL;
            S_AV1:     n_state = S_AV2;
            S_AV2:     n_state = S_EMIT;
            S_EMIT:    n_state = w_out_free ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_nbuf      <= '0;
            r_total     <= '0;
            r_seen      <= 1'b0;
            r_last      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) r_seed <= pwdata;

            if (r_state == S_EMIT && w_out_free) r_out_valid <= 1'b1;
            else if (o_hash_ch.ready)            r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_in_acc) begin
                        r_last  <= i_word_ch.last_word;
                        r_total <= r_total + (i_word_ch.last_word ? {29'd0, w_cnt_sat} : 32'd4);
                        if (w_push) begin
                            r_nbuf <= r_nbuf + 2'd1;
                            if (r_nbuf == 2'd3) r_seen <= 1'b1;
                        end
                    end
                end
                S_AB_WR, S_FOLD: r_idx <= r_idx + 2'd1;
                S_FOLD0:         r_idx <= '0;
                S_TW_WR: begin
                    if (r_idx == r_nbuf - 2'd1) r_idx <= '0;
                    else                        r_idx <= r_idx + 2'd1;
                end
                S_TB_WR: r_idx <= r_idx + 2'd1;
                S_EMIT: begin
                    if (w_out_free) begin
                        r_nbuf      <= '0;
                        r_total     <= '0;
                        r_seen      <= 1'b0;
                        r_last      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        // product held while the hash waits for the result register
        if (r_state != S_EMIT) r_prod <= w_prod;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_word <= i_word_ch.data_word;
                    r_cnt  <= w_push ? 2'd0 : w_cnt_sat[1:0];
                    if (w_push) r_buf[r_nbuf] <= i_word_ch.data_word;
                    if (w_push && r_nbuf == 2'd3 && !r_seen) begin
                        r_lane[0] <= r_seed + PRIME1 + PRIME2;
                        r_lane[1] <= r_seed + PRIME2;
                        r_lane[2] <= r_seed;
                        r_lane[3] <= r_seed - PRIME1;
                    end
                end
            end
            S_AB_WR:  r_lane[r_idx] <= r_prod;
            S_FOLD0:  r_h <= (r_seen ? 32'd0 : r_seed + PRIME5) + r_total;
            S_FOLD:   r_h <= r_h + w_fold_rot;
            S_TW_WR, S_TB_WR: r_h <= r_prod;
            S_EMIT: begin
                if (w_out_free) r_hash <= r_prod ^ (r_prod >> 16);
            end
            default: ;
        endcase
    end

    // a word that leaves the stripe unfinished returns to idle in the next cycle
    a_short_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_word_ch.last_word && r_nbuf != 2'd3) |=> (r_state == S_IDLE))
        else $error("non-finishing word did not return to idle");

    // absorbing the fourth lane leaves the stripe buffer empty
    a_absorb_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AB_WR && r_idx == 2'd3) |=> (r_nbuf == 2'd0 && r_seen))
        else $error("stripe absorb left words buffered");

    // lane fold only runs once a stripe was absorbed
    a_fold_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> r_seen)
        else $error("lane fold without any stripe");

    // emitting a hash clears the message state and shows the word
    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=>
            (r_out_valid && r_total == 32'd0 && r_nbuf == 2'd0 && !r_seen))
        else $error("message state not cleared on emit");

endmodule

`default_nettype wire
